/* rtl/hlcd_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hlcd_pkg - shared types and constants for the header/length/checksum deframer
// Phase and error codes, register indexes, reset values and the beat structs.
// ---------------------------------------------------------------------------
package hlcd_pkg;

	// Build-time cap on payload length (top-level parameter default)
	localparam int MAX_PAYLOAD_DEF = 64;

	// Field widths
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;
	localparam int ERR_W  = 3;
	localparam int ADDR_W = 2;

	// Register reset values
	localparam logic [BYTE_W-1:0] FIRST_HDR_RST  = 8'h55;
	localparam logic [BYTE_W-1:0] SECOND_HDR_RST = 8'hAA;
	localparam logic [BYTE_W-1:0] IDENT_RST      = 8'h00;
	localparam logic [LEN_W-1:0]  LIMIT_RST      = 7'd64;

	// Register indexes on the write port
	typedef enum logic [ADDR_W-1:0] {
		REG_FIRST_HDR  = 2'd0,
		REG_SECOND_HDR = 2'd1,
		REG_IDENT      = 2'd2,
		REG_LIMIT      = 2'd3
	} reg_idx_t;

	// Parse phase
	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_IDENT  = 3'd1,
		PH_LENGTH = 3'd2,
		PH_DATA   = 3'd3,
		PH_CHECK  = 3'd4
	} phase_t;

	// Result error codes
	typedef enum logic [ERR_W-1:0] {
		ERR_NONE   = 3'd0,
		ERR_HEADER = 3'd1,
		ERR_IDENT  = 3'd2,
		ERR_LENGTH = 3'd3,
		ERR_CHECK  = 3'd4
	} err_t;

	// Configuration values handed to the parser
	typedef struct packed {
		logic [BYTE_W-1:0] first_hdr;
		logic [BYTE_W-1:0] second_hdr;
		logic [BYTE_W-1:0] ident;
		logic [LEN_W-1:0]  limit;
	} cfg_t;

	// One result beat
	typedef struct packed {
		err_t error_code;
		logic frame_ok;
	} res_t;

endpackage : hlcd_pkg
`default_nettype wire

/* rtl/header_length_checksum_deframer.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// header_length_checksum_deframer - byte-stream frame finder
// Checks header, identifier, length and payload checksum; one result beat
// per received byte.
// ---------------------------------------------------------------------------
//  Channel   Dir  Handshake          Payload
//  s_*       in   tvalid/tready      tdata[7:0] rx_byte
//  m_*       out  tvalid/tready      tdata[0] frame_ok, [3:1] error_code, [7:4] zero
//  cfg_*     in   cfg_we             cfg_addr register index, cfg_data value
//
//  One byte per cycle while s_tready is high; each result is registered.
//  Parse state updates in the cycle the byte is taken; output register plus
//  skid slot let one more byte be taken while the output is stalled.
//  s_tready drops only while the skid slot is full.
//  Reset restores header 0x55/0xAA, identifier 0x00, limit 64, hunting phase.
// ---------------------------------------------------------------------------
module header_length_checksum_deframer import hlcd_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,   // [7:0] rx_byte
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [7:0]             m_tdata,   // [0] frame_ok, [3:1] error_code, [7:4] zero
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_addr,
	input  wire logic [BYTE_W-1:0] cfg_data
);

	cfg_t cfg_q;
	res_t res;
	res_t out_q, skid_q;
	logic out_vld_q, skid_vld_q;
	logic take, pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_hdr  <= FIRST_HDR_RST;
			cfg_q.second_hdr <= SECOND_HDR_RST;
			cfg_q.ident      <= IDENT_RST;
			cfg_q.limit      <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_FIRST_HDR:  cfg_q.first_hdr  <= cfg_data;
				REG_SECOND_HDR: cfg_q.second_hdr <= cfg_data;
				REG_IDENT:      cfg_q.ident      <= cfg_data;
				REG_LIMIT:      cfg_q.limit      <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !skid_vld_q;
	assign take     = s_tvalid && s_tready;
	assign pop      = out_vld_q && m_tready;

	hlcd_parse #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.rx_byte(s_tdata),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Output register and skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= take;
			end
		end else if (take) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (take) begin
				out_q <= res;
			end
		end else if (take) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0000, out_q.error_code, out_q.frame_ok};

endmodule : header_length_checksum_deframer
`default_nettype wire

/* rtl/hlcd_parse.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hlcd_parse - frame parse state and per-byte result
// Holds phase, length, count and running sum; gives the result of the byte
// offered this cycle and advances the state when that byte is taken.
// ---------------------------------------------------------------------------
module hlcd_parse import hlcd_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire cfg_t              cfg,
	output res_t                   res
);

	// Cap from the parameter, never above what the length field holds
	localparam int CAP = (MAX_PAYLOAD > ((1 << LEN_W) - 1)) ? ((1 << LEN_W) - 1) : MAX_PAYLOAD;
	localparam logic [LEN_W-1:0] CAP_V = LEN_W'(CAP);

	phase_t             phase_q, phase_d;
	logic               seen_q, seen_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [LEN_W-1:0]   cnt_q, cnt_d;
	logic [BYTE_W-1:0]  sum_q, sum_d;
	logic [LEN_W-1:0]   eff_lim;
	logic [LEN_W-1:0]   cnt_inc;
	logic [BYTE_W-1:0]  sum_add;
	logic [BYTE_W-1:0]  chk_exp;

	assign eff_lim = (cfg.limit > CAP_V) ? CAP_V : cfg.limit;
	assign cnt_inc = cnt_q + LEN_W'(1);
	assign sum_add = sum_q + rx_byte;
	assign chk_exp = BYTE_W'(0) - sum_q;

	// Next state and result
	always_comb begin
		phase_d = phase_q;
		seen_d  = seen_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		sum_d   = sum_q;
		res     = '{error_code: ERR_NONE, frame_ok: 1'b0};
		if (rx_byte == cfg.first_hdr) begin
			// first header byte restarts parsing anywhere
			phase_d = PH_HUNT;
			seen_d  = 1'b1;
			len_d   = '0;
			cnt_d   = '0;
			sum_d   = '0;
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					if (seen_q && rx_byte == cfg.second_hdr) begin
						phase_d = PH_IDENT;
					end else begin
						res.error_code = ERR_HEADER;
						phase_d = PH_HUNT; seen_d = 1'b0;
						len_d = '0; cnt_d = '0; sum_d = '0;
					end
				end
				PH_IDENT: begin
					if (rx_byte == cfg.ident) begin
						phase_d = PH_LENGTH;
					end else begin
						res.error_code = ERR_IDENT;
						phase_d = PH_HUNT; seen_d = 1'b0;
						len_d = '0; cnt_d = '0; sum_d = '0;
					end
				end
				PH_LENGTH: begin
					if (rx_byte <= {1'b0, eff_lim}) begin
						len_d   = rx_byte[LEN_W-1:0];
						cnt_d   = '0;
						sum_d   = '0;
						// zero length goes straight to the checksum
						phase_d = (rx_byte[LEN_W-1:0] == '0) ? PH_CHECK : PH_DATA;
					end else begin
						res.error_code = ERR_LENGTH;
						phase_d = PH_HUNT; seen_d = 1'b0;
						len_d = '0; cnt_d = '0; sum_d = '0;
					end
				end
				PH_DATA: begin
					sum_d = sum_add;
					cnt_d = cnt_inc;
					if (cnt_inc >= len_q) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					if (rx_byte == chk_exp) begin
						res.frame_ok = 1'b1;
					end else begin
						res.error_code = ERR_CHECK;
					end
					phase_d = PH_HUNT; seen_d = 1'b0;
					len_d = '0; cnt_d = '0; sum_d = '0;
				end
				default: begin
					phase_d = PH_HUNT; seen_d = 1'b0;
					len_d = '0; cnt_d = '0; sum_d = '0;
				end
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			seen_q  <= 1'b0;
			len_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			seen_q  <= seen_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
		end
	end

endmodule : hlcd_parse
`default_nettype wire

/* rtl/hlcd_checker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hlcd_checker - port-level checks for the deframer
// Watches result beats and the output handshake; bound to the top level.
// ---------------------------------------------------------------------------
module hlcd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);

	// a good frame never carries an error code
	a_ok_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[3:1] != 3'd0))
		else $error("frame_ok with nonzero error_code");

	// error code stays within its defined set, pad bits zero
	a_code_rng: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:1] <= 3'd4 && m_tdata[7:4] == 4'd0))
		else $error("bad error_code or pad bits");

	// a byte taken into an empty output shows up next cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !m_tvalid) |=> m_tvalid)
		else $error("result beat missing");

	// input stays open while output is empty
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule : hlcd_checker

bind header_length_checksum_deframer hlcd_checker u_hlcd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire

/* tb/tb_header_length_checksum_deframer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_header_length_checksum_deframer - regression for the byte-stream deframer
// Sends bytes into the input stream. Most of them form frames with random
// content, and the rest are noise and broken frames. A local model of the
// parser predicts the frame_ok/error_code verdict for each accepted byte, and
// every result beat is checked against the oldest pending verdict. The run
// covers reset, extreme and random register settings under several
// idle/stall patterns.
// ---------------------------------------------------------------------------
module tb_header_length_checksum_deframer;
	import hlcd_pkg::*;

	localparam int MAX_LEN     = MAX_PAYLOAD_DEF;
	localparam int CYCLE_LIMIT = 200_000;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata  = 8'h00;   // [7:0] rx_byte
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;            // [0] frame_ok, [3:1] error_code, [7:4] zero
	logic              cfg_we   = 1'b0;
	logic [ADDR_W-1:0] cfg_addr = REG_FIRST_HDR;
	logic [BYTE_W-1:0] cfg_data = 8'h00;

	// Shadow copy of the registers
	logic [7:0] hdr1_reg;
	logic [7:0] hdr2_reg;
	logic [7:0] ident_reg;
	logic [6:0] limit_reg;

	// Parser state of the model
	phase_t     parse_phase;
	logic       seen_hdr;
	logic [6:0] pay_len;
	logic [6:0] pay_cnt;
	logic [7:0] run_sum;

	res_t pending_verdicts[$];
	int   mismatch_cnt = 0;
	int   cycle_cnt    = 0;
	int   bytes_sent   = 0;
	int   send_idle_pct  = 0;
	int   stall_pct      = 0;

	header_length_checksum_deframer #(
		.MAX_PAYLOAD(MAX_LEN)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("header_length_checksum_deframer regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------
	function automatic void clear_parse();
		parse_phase = PH_HUNT;
		seen_hdr    = 1'b0;
		pay_len     = '0;
		pay_cnt     = '0;
		run_sum     = '0;
	endfunction

	// Accepted length: register value, capped by the build-time maximum
	function automatic int len_cap();
		int cap;
		cap = limit_reg;
		if (cap > MAX_LEN)
			cap = MAX_LEN;
		if (cap > 127)
			cap = 127;
		return cap;
	endfunction

	function automatic res_t predict_verdict(input logic [7:0] b);
		res_t v;
		v.frame_ok   = 1'b0;
		v.error_code = ERR_NONE;
		// first header byte restarts parsing from anywhere
		if (b == hdr1_reg) begin
			clear_parse();
			seen_hdr = 1'b1;
		end else begin
			case (parse_phase)
				PH_HUNT: begin
					if (seen_hdr && b == hdr2_reg) begin
						parse_phase = PH_IDENT;
					end else begin
						v.error_code = ERR_HEADER;
						clear_parse();
					end
				end
				PH_IDENT: begin
					if (b == ident_reg) begin
						parse_phase = PH_LENGTH;
					end else begin
						v.error_code = ERR_IDENT;
						clear_parse();
					end
				end
				PH_LENGTH: begin
					if (int'(b) <= len_cap()) begin
						pay_len     = b[6:0];
						pay_cnt     = '0;
						run_sum     = '0;
						parse_phase = (b[6:0] == 7'd0) ? PH_CHECK : PH_DATA;
					end else begin
						v.error_code = ERR_LENGTH;
						clear_parse();
					end
				end
				PH_DATA: begin
					run_sum = run_sum + b;
					pay_cnt = pay_cnt + 7'd1;
					if (pay_cnt >= pay_len)
						parse_phase = PH_CHECK;
				end
				PH_CHECK: begin
					if (b == 8'(9'h100 - {1'b0, run_sum}))
						v.frame_ok = 1'b1;
					else
						v.error_code = ERR_CHECK;
					clear_parse();
				end
				default: clear_parse();
			endcase
		end
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// Receiver back-pressure, redrawn every cycle
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// One byte on the input stream; returns at the edge where it is taken
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		pending_verdicts.push_back(predict_verdict(b));
		bytes_sent++;
	endtask

	// Hold off input until every pending verdict has been checked
	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_FIRST_HDR:  hdr1_reg  = val;
			REG_SECOND_HDR: hdr2_reg  = val;
			REG_IDENT:      ident_reg = val;
			REG_LIMIT:      limit_reg = val[6:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_registers(input logic [7:0] h1, input logic [7:0] h2,
			input logic [7:0] id, input logic [7:0] lim);
		cfg_write(REG_FIRST_HDR, h1);
		cfg_write(REG_SECOND_HDR, h2);
		cfg_write(REG_IDENT, id);
		cfg_write(REG_LIMIT, lim);
	endtask

	// Traffic: mostly complete frames, the rest broken frames and noise.
	// mode: 0 none, 1 sender idle, 2 receiver stall, 3 both
	task automatic run_traffic(input int nbytes, input int mode);
		int         start_cnt;
		int         r;
		int         len;
		int         cap;
		int         n;
		bit         paused;
		logic [7:0] b;
		logic [7:0] sum;
		logic [7:0] head [4];
		case (mode)
			1:       begin send_idle_pct = 47; stall_pct = 0;  end
			2:       begin send_idle_pct = 0;  stall_pct = 47; end
			3:       begin send_idle_pct = 36; stall_pct = 36; end
			default: begin send_idle_pct = 0;  stall_pct = 0;  end
		endcase
		start_cnt = bytes_sent;
		paused    = 1'b0;
		while (bytes_sent - start_cnt < nbytes) begin
			cap = len_cap();
			if ($urandom_range(9) == 0)
				len = cap;
			else
				len = $urandom_range((cap < 8) ? cap : 8);
			head = '{hdr1_reg, hdr2_reg, ident_reg, 8'(len)};
			r = $urandom_range(99);
			if (r < 70) begin
				// well-formed frame, checksum mostly right
				foreach (head[i])
					send_byte(head[i]);
				sum = 8'h00;
				for (int i = 0; i < len; i++) begin
					b = 8'($urandom);
					if (b == hdr1_reg && $urandom_range(9) != 0)
						b = ~b;
					sum = sum + b;
					send_byte(b);
				end
				b = 8'(9'h100 - {1'b0, sum});
				if ($urandom_range(9) == 0)
					b = b ^ 8'($urandom_range(255, 1));
				send_byte(b);
			end else if (r < 78) begin
				// frame cut short
				n = $urandom_range(4, 1);
				for (int i = 0; i < n; i++)
					send_byte(head[i]);
			end else if (r < 86) begin
				// wrong identifier
				send_byte(hdr1_reg);
				send_byte(hdr2_reg);
				send_byte(ident_reg ^ 8'($urandom_range(255, 1)));
			end else if (r < 92) begin
				// length above the limit
				send_byte(hdr1_reg);
				send_byte(hdr2_reg);
				send_byte(ident_reg);
				send_byte(8'($urandom_range(255, cap + 1)));
			end else begin
				n = $urandom_range(4, 1);
				for (int i = 0; i < n; i++)
					send_byte(8'($urandom));
			end
			// one drain in the middle of the phase
			if (!paused && bytes_sent - start_cnt >= nbytes / 2) begin
				paused = 1'b1;
				wait_for_results();
			end
		end
		wait_for_results();
	endtask

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: result beat with nothing pending: tdata=%h",
						$realtime, m_tdata);
			end else begin
				want = pending_verdicts.pop_front();
				if (m_tdata[0] !== want.frame_ok || m_tdata[3:1] !== want.error_code ||
						m_tdata[7:4] !== 4'h0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display({"%0t: mismatch: frame_ok exp %0d got %0d, ",
							"error_code exp %0d got %0d, pad got %h"}, $realtime,
							want.frame_ok, m_tdata[0], want.error_code, m_tdata[3:1],
							m_tdata[7:4]);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Each special case once, at reset register values
	task automatic test_directed_cases();
		logic [7:0] seq [$];
		send_idle_pct = 0;
		stall_pct     = 0;
		seq = '{8'h00,                                 // stray byte while hunting
			8'h55, 8'hAA, 8'h00, 8'h00, 8'h00,         // zero length, good checksum
			8'h55, 8'hAA, 8'h01,                       // wrong identifier
			8'h55, 8'h00,                              // wrong second header
			8'h55, 8'hAA, 8'h00, 8'h41,                // length one above limit
			8'h55, 8'hAA, 8'h00, 8'h02, 8'hFF,         // header inside payload,
			8'h55, 8'hAA, 8'h00, 8'h00, 8'h01,         // then bad checksum
			8'h55, 8'hAA, 8'h00, 8'h01, 8'h10, 8'h55}; // header as checksum
		foreach (seq[i])
			send_byte(seq[i]);
		wait_for_results();
	endtask

	task automatic test_default_registers();
		set_registers(FIRST_HDR_RST, SECOND_HDR_RST, IDENT_RST, 8'(LIMIT_RST));
		for (int m = 0; m < 4; m++)
			run_traffic(70, m);
	endtask

	// Zero limit with first header zero: the zero length byte restarts
	// parsing, so no frame can complete
	task automatic test_low_extremes();
		set_registers(8'h00, 8'hFF, 8'hFF, 8'h00);
		run_traffic(75, 1);
		run_traffic(75, 3);
	endtask

	// Limit register at its top (bit 7 of the write data is dropped)
	task automatic test_high_extremes();
		set_registers(8'hFF, 8'h00, 8'h80, 8'hFF);
		run_traffic(125, 2);
		run_traffic(125, 0);
	endtask

	// Second header or identifier equal to the first header byte
	task automatic test_header_collisions();
		logic [7:0] h;
		h = 8'($urandom);
		set_registers(h, h, 8'($urandom), 8'd5);
		run_traffic(60, 3);
		h = 8'($urandom);
		set_registers(h, ~h, h, 8'd64);
		run_traffic(60, 0);
	endtask

	task automatic test_random_registers();
		logic [7:0] h1;
		logic [7:0] h2;
		logic [7:0] lim;
		for (int k = 0; k < 6; k++) begin
			h1 = 8'($urandom);
			h2 = 8'($urandom);
			if (h2 == h1)
				h2 = ~h1;
			case (k)
				0:       lim = 8'd1;
				1:       lim = 8'd64;
				default: lim = 8'($urandom_range(127));
			endcase
			set_registers(h1, h2, 8'($urandom), lim);
			run_traffic(120, k % 4);
		end
	endtask

	initial begin
		hdr1_reg  = FIRST_HDR_RST;
		hdr2_reg  = SECOND_HDR_RST;
		ident_reg = IDENT_RST;
		limit_reg = LIMIT_RST;
		clear_parse();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_default_registers();
		test_low_extremes();
		test_high_extremes();
		test_header_collisions();
		test_random_registers();

		// drain and let the output settle
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("header_length_checksum_deframer regression: pass");
		else
			$display("header_length_checksum_deframer regression: fail");
		$finish;
	end

endmodule
